[rtl/core/hsvrgb_pkg.sv]
// Shared constants, payload types and sector codes of the HSV to RGB pipeline.
package hsvrgb_pkg;

  // Fraction width of the hue position inside a sector (8 to 24)
  localparam int FRAC_BITS = 16;

  // Saturation and value: scale 2^15, clamped to 1.0
  localparam int UNIT_W     = 16;
  localparam int UNIT_SHIFT = 15;
  localparam logic [UNIT_W-1:0] UNIT_ONE = 16'd32768;

  // Hue: 1/64 degree units
  localparam int HUE_W  = 16;
  localparam int HWRAP_W = 15;
  localparam logic [HUE_W-1:0] HUE_FULL   = 16'd23040;
  localparam logic [HUE_W-1:0] HUE_TWICE  = 16'd46080;
  localparam logic [HWRAP_W-1:0] HUE_SECTOR = 15'd3840;
  localparam int SECTOR_W = 3;
  localparam int REM_W    = 12;

  // Fraction f = floor(rem * 2^FRAC_BITS / 3840) = floor(y / 15),
  // y = rem << (FRAC_BITS - 8), done as reciprocal multiply plus one fixup
  localparam int DIV_D    = 15;
  localparam int Y_W      = REM_W + FRAC_BITS - 8;
  localparam int DIV_K    = Y_W;
  localparam int DIV_M    = (2 ** DIV_K) / DIV_D;
  localparam int DIV_M_W  = DIV_K - 3;
  localparam int PROD_W   = Y_W + DIV_M_W;
  localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(2 ** FRAC_BITS);

  // Sector codes, 60 degrees each
  localparam logic [SECTOR_W-1:0] SEC_RY = 3'd0;  // red to yellow
  localparam logic [SECTOR_W-1:0] SEC_YG = 3'd1;  // yellow to green
  localparam logic [SECTOR_W-1:0] SEC_GC = 3'd2;  // green to cyan
  localparam logic [SECTOR_W-1:0] SEC_CB = 3'd3;  // cyan to blue
  localparam logic [SECTOR_W-1:0] SEC_BM = 3'd4;  // blue to magenta
  localparam logic [SECTOR_W-1:0] SEC_MR = 3'd5;  // magenta to red

  // Payload after sector split
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [REM_W-1:0]    rem;
    logic [UNIT_W-1:0]   s;
    logic [UNIT_W-1:0]   v;
  } sect_t;

  // Payload after fraction
  typedef struct packed {
    logic [SECTOR_W-1:0]  sector;
    logic [FRAC_BITS-1:0] f;
    logic [UNIT_W-1:0]    s;
    logic [UNIT_W-1:0]    v;
  } frac_t;

  // Payload with channel terms
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [UNIT_W-1:0]   v;
    logic [UNIT_W-1:0]   p;
    logic [UNIT_W-1:0]   q;
    logic [UNIT_W-1:0]   t;
  } term_t;

endpackage

[rtl/core/hsvrgb_sector.sv]
// Stages 1-2: hue wrap, saturation/value clamp, sector and remainder split.
module hsvrgb_sector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
  input  logic [hsvrgb_pkg::UNIT_W-1:0] saturation,
  input  logic [hsvrgb_pkg::UNIT_W-1:0] brightness,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output hsvrgb_pkg::sect_t             dn_data
);

  logic                            a_vld_r;
  logic                            b_vld_r;
  logic                            a_ready;
  logic                            b_ready;
  logic [hsvrgb_pkg::HWRAP_W-1:0]  h_nxt;
  logic [hsvrgb_pkg::HWRAP_W-1:0]  h_r;
  logic [hsvrgb_pkg::UNIT_W-1:0]   s_nxt;
  logic [hsvrgb_pkg::UNIT_W-1:0]   v_nxt;
  logic [hsvrgb_pkg::UNIT_W-1:0]   s_r;
  logic [hsvrgb_pkg::UNIT_W-1:0]   v_r;
  logic [hsvrgb_pkg::SECTOR_W-1:0] sec_nxt;
  logic [hsvrgb_pkg::HWRAP_W-1:0]  base;
  hsvrgb_pkg::sect_t               b_data_r;

  assign b_ready  = !b_vld_r || dn_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign up_ready = a_ready;
  assign dn_valid = b_vld_r;
  assign dn_data  = b_data_r;

  // Hue below 65536 wraps with at most two subtractions of 360 degrees
  always_comb begin
    if (hue >= hsvrgb_pkg::HUE_TWICE) begin
      h_nxt = hsvrgb_pkg::HWRAP_W'(hue - hsvrgb_pkg::HUE_TWICE);
    end else if (hue >= hsvrgb_pkg::HUE_FULL) begin
      h_nxt = hsvrgb_pkg::HWRAP_W'(hue - hsvrgb_pkg::HUE_FULL);
    end else begin
      h_nxt = hsvrgb_pkg::HWRAP_W'(hue);
    end
    s_nxt = (saturation > hsvrgb_pkg::UNIT_ONE) ? hsvrgb_pkg::UNIT_ONE : saturation;
    v_nxt = (brightness > hsvrgb_pkg::UNIT_ONE) ? hsvrgb_pkg::UNIT_ONE : brightness;
  end

  // Sector = number of sector boundaries at or below the wrapped hue
  always_comb begin
    sec_nxt = hsvrgb_pkg::SEC_RY;
    base    = '0;
    for (int k = 1; k < 6; k++) begin
      if (h_r >= hsvrgb_pkg::HWRAP_W'(k * 3840)) begin
        sec_nxt = hsvrgb_pkg::SECTOR_W'(k);
        base    = hsvrgb_pkg::HWRAP_W'(k * 3840);
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= up_valid;
    end
    if (a_ready && up_valid) begin
      h_r <= h_nxt;
      s_r <= s_nxt;
      v_r <= v_nxt;
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_vld_r;
    end
    if (b_ready && a_vld_r) begin
      b_data_r.sector <= sec_nxt;
      b_data_r.rem    <= hsvrgb_pkg::REM_W'(h_r - base);
      b_data_r.s      <= s_r;
      b_data_r.v      <= v_r;
    end
  end

endmodule

[rtl/core/hsvrgb_frac.sv]
// Stages 3-4: sector fraction by reciprocal multiply and one-step fixup.
module hsvrgb_frac (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsvrgb_pkg::sect_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsvrgb_pkg::frac_t dn_data
);

  localparam logic [hsvrgb_pkg::DIV_M_W-1:0] M_V =
    hsvrgb_pkg::DIV_M_W'(hsvrgb_pkg::DIV_M);

  logic                             a_vld_r;
  logic                             b_vld_r;
  logic                             a_ready;
  logic                             b_ready;
  logic [hsvrgb_pkg::Y_W-1:0]       y_in;
  logic [hsvrgb_pkg::PROD_W-1:0]    prod;
  logic [hsvrgb_pkg::PROD_W-1:0]    prod_r;
  hsvrgb_pkg::sect_t                a_data_r;
  logic [hsvrgb_pkg::Y_W-1:0]       y_a;
  logic [hsvrgb_pkg::FRAC_BITS-1:0] q0;
  logic [hsvrgb_pkg::Y_W-1:0]       q15;
  logic [hsvrgb_pkg::Y_W-1:0]       rmd;
  logic [hsvrgb_pkg::FRAC_BITS-1:0] f_nxt;
  hsvrgb_pkg::frac_t                b_data_r;

  assign b_ready  = !b_vld_r || dn_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign up_ready = a_ready;
  assign dn_valid = b_vld_r;
  assign dn_data  = b_data_r;

  // Estimate: floor(y * M / 2^K), never above the true quotient, at most one below
  always_comb begin
    y_in = hsvrgb_pkg::Y_W'(up_data.rem) << (hsvrgb_pkg::FRAC_BITS - 8);
    prod = {{hsvrgb_pkg::DIV_M_W{1'b0}}, y_in} * {{hsvrgb_pkg::Y_W{1'b0}}, M_V};
  end

  // Fixup: remainder of 15 or more bumps the quotient
  always_comb begin
    y_a   = hsvrgb_pkg::Y_W'(a_data_r.rem) << (hsvrgb_pkg::FRAC_BITS - 8);
    q0    = prod_r[hsvrgb_pkg::DIV_K +: hsvrgb_pkg::FRAC_BITS];
    q15   = (hsvrgb_pkg::Y_W'(q0) << 4) - hsvrgb_pkg::Y_W'(q0);
    rmd   = y_a - q15;
    f_nxt = q0 + hsvrgb_pkg::FRAC_BITS'(rmd >= hsvrgb_pkg::Y_W'(hsvrgb_pkg::DIV_D));
  end

  // Stage 3 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= up_valid;
    end
    if (a_ready && up_valid) begin
      prod_r   <= prod;
      a_data_r <= up_data;
    end
  end

  // Stage 4 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_vld_r;
    end
    if (b_ready && a_vld_r) begin
      b_data_r.sector <= a_data_r.sector;
      b_data_r.f      <= f_nxt;
      b_data_r.s      <= a_data_r.s;
      b_data_r.v      <= a_data_r.v;
    end
  end

endmodule

[rtl/core/hsvrgb_terms.sv]
// Stages 5-6: p, q and t terms from saturation, fraction and value.
module hsvrgb_terms (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsvrgb_pkg::frac_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsvrgb_pkg::term_t dn_data
);

  localparam int SF_W = hsvrgb_pkg::UNIT_W + hsvrgb_pkg::FRAC_BITS;
  localparam int SC_W = SF_W + 1;
  localparam int PV_W = 2 * hsvrgb_pkg::UNIT_W;

  logic                             a_vld_r;
  logic                             b_vld_r;
  logic                             a_ready;
  logic                             b_ready;
  logic [hsvrgb_pkg::FRAC_BITS:0]   onef;
  logic [SF_W-1:0]                  sf_full;
  logic [SC_W-1:0]                  sc_full;
  logic [hsvrgb_pkg::UNIT_W-1:0]    sf;
  logic [hsvrgb_pkg::UNIT_W-1:0]    sc;
  logic [hsvrgb_pkg::UNIT_W-1:0]    up_r;
  logic [hsvrgb_pkg::UNIT_W-1:0]    uq_r;
  logic [hsvrgb_pkg::UNIT_W-1:0]    ut_r;
  logic [hsvrgb_pkg::UNIT_W-1:0]    v_r;
  logic [hsvrgb_pkg::SECTOR_W-1:0]  sec_r;
  logic [PV_W-1:0]                  pp;
  logic [PV_W-1:0]                  qp;
  logic [PV_W-1:0]                  tp;
  hsvrgb_pkg::term_t                b_data_r;

  assign b_ready  = !b_vld_r || dn_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign up_ready = a_ready;
  assign dn_valid = b_vld_r;
  assign dn_data  = b_data_r;

  // s*f and s*(1-f), truncated back to unit scale
  always_comb begin
    onef    = hsvrgb_pkg::ONE_F - {1'b0, up_data.f};
    sf_full = SF_W'(up_data.s) * SF_W'(up_data.f);
    sc_full = SC_W'(up_data.s) * SC_W'(onef);
    sf      = sf_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::UNIT_W];
    sc      = sc_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::UNIT_W];
  end

  // v times each complement; zero saturation makes all three equal v
  always_comb begin
    pp = PV_W'(v_r) * PV_W'(up_r);
    qp = PV_W'(v_r) * PV_W'(uq_r);
    tp = PV_W'(v_r) * PV_W'(ut_r);
  end

  // Stage 5 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= up_valid;
    end
    if (a_ready && up_valid) begin
      up_r  <= hsvrgb_pkg::UNIT_ONE - up_data.s;
      uq_r  <= hsvrgb_pkg::UNIT_ONE - sf;
      ut_r  <= hsvrgb_pkg::UNIT_ONE - sc;
      v_r   <= up_data.v;
      sec_r <= up_data.sector;
    end
  end

  // Stage 6 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_vld_r;
    end
    if (b_ready && a_vld_r) begin
      b_data_r.sector <= sec_r;
      b_data_r.v      <= v_r;
      b_data_r.p      <= pp[hsvrgb_pkg::UNIT_SHIFT +: hsvrgb_pkg::UNIT_W];
      b_data_r.q      <= qp[hsvrgb_pkg::UNIT_SHIFT +: hsvrgb_pkg::UNIT_W];
      b_data_r.t      <= tp[hsvrgb_pkg::UNIT_SHIFT +: hsvrgb_pkg::UNIT_W];
    end
  end

endmodule

[rtl/core/hsvrgb_out.sv]
// Stage 7: sector swizzle, scaling to 8-bit channels, output register.
module hsvrgb_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsvrgb_pkg::term_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  logic                          vld_r;
  logic                          ready;
  logic [hsvrgb_pkg::UNIT_W-1:0] r_x;
  logic [hsvrgb_pkg::UNIT_W-1:0] g_x;
  logic [hsvrgb_pkg::UNIT_W-1:0] b_x;
  logic [7:0]                    red_r;
  logic [7:0]                    green_r;
  logic [7:0]                    blue_r;

  // floor(x * 255 / 2^15) as (x*256 - x) >> 15
  function automatic logic [7:0] to_byte(input logic [hsvrgb_pkg::UNIT_W-1:0] x);
    logic [23:0] m;
    m = ({8'd0, x} << 8) - {8'd0, x};
    return m[hsvrgb_pkg::UNIT_SHIFT +: 8];
  endfunction

  assign ready    = !vld_r || dn_ready;
  assign up_ready = ready;
  assign dn_valid = vld_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

  // Sector picks which term drives each channel
  always_comb begin
    case (up_data.sector)
      hsvrgb_pkg::SEC_RY: begin
        r_x = up_data.v; g_x = up_data.t; b_x = up_data.p;
      end
      hsvrgb_pkg::SEC_YG: begin
        r_x = up_data.q; g_x = up_data.v; b_x = up_data.p;
      end
      hsvrgb_pkg::SEC_GC: begin
        r_x = up_data.p; g_x = up_data.v; b_x = up_data.t;
      end
      hsvrgb_pkg::SEC_CB: begin
        r_x = up_data.p; g_x = up_data.q; b_x = up_data.v;
      end
      hsvrgb_pkg::SEC_BM: begin
        r_x = up_data.t; g_x = up_data.p; b_x = up_data.v;
      end
      default: begin
        r_x = up_data.v; g_x = up_data.p; b_x = up_data.q;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= up_valid;
    end
    if (ready && up_valid) begin
      red_r   <= to_byte(r_x);
      green_r <= to_byte(g_x);
      blue_r  <= to_byte(b_x);
    end
  end

endmodule

[rtl/core/hsv_to_rgb_converter.sv]
// Top level of the HSV to 8-bit RGB pixel converter.
//
// Input channel in_valid/in_ready carries one pixel per item: in_hue in 1/64
// degree units (wrapped modulo 360 degrees), in_saturation and in_brightness
// in 1/32768 units, clamped to 1.0. The result channel out_valid/out_ready
// carries out_red, out_green, out_blue, each floor(channel * 255).
// Throughput is one item per clock while out_ready is high: each of the seven
// pipeline stages holds one item, and the deepest single step is one multiply
// of at most 20x17 bits. Every stage has its own valid bit; a stage loads
// when it is empty or the stage after it moves, so bubbles close up while
// out_ready is low and up to seven items are held. in_ready falls only once
// all stages are full. Synchronous active-low reset empties the pipeline;
// payload is not cleared.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_hue,
  input  logic [15:0] in_saturation,
  input  logic [15:0] in_brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  logic              sec_valid;
  logic              sec_ready;
  hsvrgb_pkg::sect_t sec_data;
  logic              frac_valid;
  logic              frac_ready;
  hsvrgb_pkg::frac_t frac_data;
  logic              term_valid;
  logic              term_ready;
  hsvrgb_pkg::term_t term_data;

  hsvrgb_sector u_sector (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .dn_valid   (sec_valid),
    .dn_ready   (sec_ready),
    .dn_data    (sec_data)
  );

  hsvrgb_frac u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sec_valid),
    .up_ready (sec_ready),
    .up_data  (sec_data),
    .dn_valid (frac_valid),
    .dn_ready (frac_ready),
    .dn_data  (frac_data)
  );

  hsvrgb_terms u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (frac_valid),
    .up_ready (frac_ready),
    .up_data  (frac_data),
    .dn_valid (term_valid),
    .dn_ready (term_ready),
    .dn_data  (term_data)
  );

  hsvrgb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (term_valid),
    .up_ready (term_ready),
    .up_data  (term_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

endmodule

[rtl/core/hsvrgb_checker.sv]
// Port-level assertions for the HSV to RGB converter, bound to the top level.
module hsvrgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_saturation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A waiting receiver never starves the input: no stage can be blocked
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  // Gray item accepted with an unstalled receiver reaches the output as gray
  a_gray_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_valid && in_ready && (in_saturation == 16'd0), 7) &&
     $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) &&
     $past(out_ready, 4) && $past(out_ready, 5) && $past(out_ready, 6) &&
     $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5) && $past(rst_n, 6) && $past(rst_n, 7))
    |-> out_valid && (out_red == out_green) && (out_green == out_blue))
    else $error("gray item not delivered as gray after seven cycles");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_saturation (in_saturation),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

[tb/hsv_rgb_checker.sv]
// Scoreboard for the HSV to RGB converter: predicts each pixel and checks results in order.
`timescale 1ns / 100ps

module hsv_rgb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_hue,
  input  logic [15:0] in_saturation,
  input  logic [15:0] in_brightness,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  output int          mismatches,
  output int          pending
);

  // Expected pixel, with the HSV input kept for messages
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] bri;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  pixel_t rgb_expected[$];
  int     fail_total;

  initial begin
    mismatches = 0;
    pending    = 0;
    fail_total = 0;
  end

  // Unit-scaled term to 8-bit channel: floor(x * 255 / 2^15)
  function automatic logic [7:0] unit_to_byte(input longint unsigned x);
    return 8'((x * 255) >> hsvrgb_pkg::UNIT_SHIFT);
  endfunction

  // Fixed-point HSV to RGB, truncating at every step
  function automatic pixel_t rgb_from_hsv(input logic [15:0] hue, input logic [15:0] sat,
                                          input logic [15:0] bri);
    pixel_t                          px;
    longint unsigned                 h, s, v, f, one_f, one_u, p, q, t, r, g, b;
    logic [hsvrgb_pkg::SECTOR_W-1:0] sec;
    px.hue = hue;
    px.sat = sat;
    px.bri = bri;
    one_u  = hsvrgb_pkg::UNIT_ONE;
    one_f  = 64'd1 << hsvrgb_pkg::FRAC_BITS;
    h      = longint'(hue) % hsvrgb_pkg::HUE_FULL;
    s      = (sat > hsvrgb_pkg::UNIT_ONE) ? one_u : longint'(sat);
    v      = (bri > hsvrgb_pkg::UNIT_ONE) ? one_u : longint'(bri);
    sec    = hsvrgb_pkg::SECTOR_W'(h / hsvrgb_pkg::HUE_SECTOR);
    f      = ((h % hsvrgb_pkg::HUE_SECTOR) << hsvrgb_pkg::FRAC_BITS) / hsvrgb_pkg::HUE_SECTOR;
    // no saturation: gray from value alone
    if (s == 0) begin
      px.red   = unit_to_byte(v);
      px.green = unit_to_byte(v);
      px.blue  = unit_to_byte(v);
      return px;
    end
    p = (v * (one_u - s)) >> hsvrgb_pkg::UNIT_SHIFT;
    q = (v * (one_u - ((s * f) >> hsvrgb_pkg::FRAC_BITS))) >> hsvrgb_pkg::UNIT_SHIFT;
    t = (v * (one_u - ((s * (one_f - f)) >> hsvrgb_pkg::FRAC_BITS))) >> hsvrgb_pkg::UNIT_SHIFT;
    // sector swizzle
    case (sec)
      hsvrgb_pkg::SEC_RY: begin r = v; g = t; b = p; end
      hsvrgb_pkg::SEC_YG: begin r = q; g = v; b = p; end
      hsvrgb_pkg::SEC_GC: begin r = p; g = v; b = t; end
      hsvrgb_pkg::SEC_CB: begin r = p; g = q; b = v; end
      hsvrgb_pkg::SEC_BM: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    px.red   = unit_to_byte(r);
    px.green = unit_to_byte(g);
    px.blue  = unit_to_byte(b);
    return px;
  endfunction

  // Queue on input accept, compare on output accept
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n) begin
      if (in_valid && in_ready)
        rgb_expected.push_back(rgb_from_hsv(in_hue, in_saturation, in_brightness));
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     out_red, out_green, out_blue);
        end else begin
          exp_px = rgb_expected.pop_front();
          if (out_red !== exp_px.red || out_green !== exp_px.green ||
              out_blue !== exp_px.blue) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: h=%0d s=%0d v=%0d expected r/g/b %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, exp_px.hue, exp_px.sat, exp_px.bri,
                       exp_px.red, exp_px.green, exp_px.blue,
                       out_red, out_green, out_blue);
          end
        end
      end
    end
    mismatches <= fail_total;
    pending    <= rgb_expected.size();
  end

endmodule

[tb/tb_hsv_to_rgb_converter.sv]
// Testbench top for the HSV to RGB converter: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;

  localparam int RAND_ITEMS  = 700;
  localparam int HOLD_CYCLES = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_hue;
  logic [15:0] in_saturation;
  logic [15:0] in_brightness;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  int mismatches;
  int pending;
  int idle_cycles;
  bit hold_out_req;
  bit quiet_tail;

  hsv_to_rgb_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  hsv_rgb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one pixel and hold it until accepted
  task automatic offer_pixel(input logic [15:0] h, input logic [15:0] s,
                             input logic [15:0] v);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Saturation or value: zero, exactly one, near one (either side), any 16-bit value, or up to one
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return hsvrgb_pkg::UNIT_ONE;
      2, 3:    return 16'($urandom_range(0, 65535));
      4:       return 16'($urandom_range(32760, 32776));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Hue: mostly uniform, sometimes at or one step below a sector or wrap boundary
  function automatic logic [15:0] pick_hue();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(1, 17) * hsvrgb_pkg::HUE_SECTOR - $urandom_range(0, 1));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold on request, none at the tail
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_out_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int k;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    hold_out_req  = 1'b0;
    quiet_tail    = 1'b0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sector starts at full saturation and value
    for (k = 0; k < 6; k++)
      offer_pixel(16'(k * hsvrgb_pkg::HUE_SECTOR), hsvrgb_pkg::UNIT_ONE, hsvrgb_pkg::UNIT_ONE);
    // last step before the first sector edge and before the wrap, and the wrap points
    offer_pixel(16'(hsvrgb_pkg::HUE_SECTOR - 1), hsvrgb_pkg::UNIT_ONE, hsvrgb_pkg::UNIT_ONE);
    offer_pixel(16'(hsvrgb_pkg::HUE_FULL - 1), hsvrgb_pkg::UNIT_ONE, hsvrgb_pkg::UNIT_ONE);
    offer_pixel(hsvrgb_pkg::HUE_FULL, hsvrgb_pkg::UNIT_ONE, hsvrgb_pkg::UNIT_ONE);
    offer_pixel(hsvrgb_pkg::HUE_TWICE, 16'd20000, 16'd30000);
    offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pixel(16'd0, 16'd0, 16'd0);
    // gray: zero saturation
    offer_pixel(16'd5000, 16'd0, hsvrgb_pkg::UNIT_ONE);
    offer_pixel(16'hFFFF, 16'd0, 16'd12345);
    // saturation and value above one are clamped
    offer_pixel(16'd9000, 16'hFFFF, 16'd40000);
    offer_pixel(16'd13000, 16'd32769, 16'hFFFF);
    // just under one and the smallest nonzero values
    offer_pixel(16'd2000, 16'd32767, 16'd32767);
    offer_pixel(16'd17000, 16'd1, 16'd1);
    offer_pixel(16'd7000, hsvrgb_pkg::UNIT_ONE, 16'd0);
    // magenta to red sector, then one hue above 360 degrees
    offer_pixel(16'd21000, 16'd25000, hsvrgb_pkg::UNIT_ONE);
    offer_pixel(16'd22900, hsvrgb_pkg::UNIT_ONE, 16'd18000);
    offer_pixel(16'h8000, 16'h5555, 16'hAAAA);
    pause_input(1);
    wait (pending == 0);

    // random pixels with gaps, a long output hold, then a quiet tail
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == 300)
        hold_out_req = 1'b1;
      if (k == 340) begin
        pause_input(1);
        wait (pending == 0);
      end
      if (k == RAND_ITEMS - 100)
        quiet_tail = 1'b1;
      if (!quiet_tail && !(k >= 300 && k < 340) && $urandom_range(0, 5) == 0)
        pause_input($urandom_range(1, 13));
      offer_pixel(pick_hue(), pick_unit(), pick_unit());
    end
    pause_input(1);

    // drain and verdict
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
